>>> rtl/core/rgb_to_display_pixel_compositor_core_assert.svh
// Assertion macros shared by the display pixel compositor RTL.
// No dependencies; empty bodies when SYNTHESIS is defined.
`ifndef RGB_TO_DISPLAY_PIXEL_COMPOSITOR_CORE_ASSERT_SVH
`define RGB_TO_DISPLAY_PIXEL_COMPOSITOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Checked only while out of reset
`define RGBDC_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included
`define RGBDC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RGBDC_ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define RGBDC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> rtl/core/rgbdc_pkg.sv
// Shared types, codes and helper functions of the display pixel compositor.
// No dependencies; used by rgbdc_convert and the core top level.
package rgbdc_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_MASK    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RED_MASK     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_MASK   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_DEPTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COMPOSE_MODE = 3'd4;

  // Compose modes (code 3 behaves as main only)
  localparam logic [1:0] MODE_MAIN_ONLY  = 2'd0;
  localparam logic [1:0] MODE_MAIN_UNDER = 2'd1;
  localparam logic [1:0] MODE_MENU_DRAW  = 2'd2;

  // Output depth codes
  localparam logic DEPTH_16 = 1'b0;
  localparam logic DEPTH_32 = 1'b1;

  // Reset masks
  localparam logic [15:0] BLUE_MASK_RST  = 16'h001F;
  localparam logic [15:0] RED_MASK_RST   = 16'hF800;
  localparam logic [15:0] GREEN_MASK_RST = 16'h07E0;

  // Alpha bit that marks a visible menu pixel
  localparam int unsigned ALPHA_MENU_BIT = 1;

  // Per-channel placement: bits kept (0..8) and left shift (0..8)
  typedef struct packed {
    logic [3:0] n;
    logic [3:0] sh;
  } chan_t;

  typedef struct packed {
    chan_t      blue;
    chan_t      red;
    chan_t      green;
    logic       depth;
    logic [1:0] mode;
  } cfg_t;

  typedef struct packed {
    logic [7:0] main_blue;
    logic [7:0] main_green;
    logic [7:0] main_red;
    logic [7:0] menu_blue;
    logic [7:0] menu_green;
    logic [7:0] menu_red;
    logic [7:0] alpha_flag;
  } in_item_t;

  typedef struct packed {
    logic [31:0] display_word;
    logic        write_enable;
    logic [7:0]  alpha_out;
  } res_t;

  // Lowest set bit and run of ones above it (capped at 8) -> kept bits, shift
  function automatic chan_t chan_info(input logic [15:0] mask);
    logic [4:0]  pos;
    logic [15:0] run_bits;
    logic        run;
    logic [3:0]  n;
    logic [5:0]  top;
    chan_t       c;
    pos = 5'd16;
    for (int i = 15; i >= 0; i--) begin
      if (mask[i]) begin
        pos = 5'(i);
      end
    end
    run_bits = mask >> pos;
    run = 1'b1;
    n = 4'd0;
    for (int k = 0; k < 8; k++) begin
      run = run & run_bits[k];
      n = n + {3'd0, run};
    end
    top = {1'b0, pos} + {2'd0, n};
    c.n = n;
    c.sh = (top >= 6'd8) ? 4'(top - 6'd8) : 4'd0;
    return c;
  endfunction

endpackage

>>> rtl/core/rgb_to_display_pixel_compositor_core.sv
// Display pixel compositor top level: input register, compose/pack, result register.
// Depends on rgbdc_pkg, rgbdc_convert and rgb_to_display_pixel_compositor_core_assert.svh.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  in_     | in        | in_tvalid/tready   | tdata: 7 source bytes (56 bits)
//  out_    | out       | out_tvalid/tready  | tdata: word + alpha (40), tuser: write enable
//  cfg_    | in        | cfg_valid/ready    | cfg_index (3), cfg_data (16)
//
// One item per clock while out_tready stays high; an accepted item passes the input register,
// then the result register, before out_tvalid rises for it.
// rst_n is synchronous: both stages empty and registers back to their reset masks.
// A stalled output holds the pipe; in_tready falls only when both stages are full
// and out_tready is low. cfg_ready is always high.
`include "rgb_to_display_pixel_compositor_core_assert.svh"

module rgb_to_display_pixel_compositor_core (
  input  logic                             clk,
  input  logic                             rst_n,
  // main_blue, main_green, main_red, menu_blue, menu_green, menu_red, alpha_flag
  input  logic [55:0]                      in_tdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // display_word [31:0], alpha_out [39:32]
  output logic [39:0]                      out_tdata,
  // write_enable
  output logic                             out_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rgbdc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [15:0]                      cfg_data
);

  rgbdc_pkg::cfg_t     cfg_r;
  rgbdc_pkg::in_item_t s1_item_r;
  logic                s1_valid_r;
  rgbdc_pkg::res_t     res_nxt;
  rgbdc_pkg::res_t     res_r;
  logic                out_valid_r;
  logic                s2_en;
  logic                s1_en;

  // Configuration: channel placement decoded once at write time
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.blue  <= rgbdc_pkg::chan_info(rgbdc_pkg::BLUE_MASK_RST);
      cfg_r.red   <= rgbdc_pkg::chan_info(rgbdc_pkg::RED_MASK_RST);
      cfg_r.green <= rgbdc_pkg::chan_info(rgbdc_pkg::GREEN_MASK_RST);
      cfg_r.depth <= rgbdc_pkg::DEPTH_16;
      cfg_r.mode  <= rgbdc_pkg::MODE_MAIN_ONLY;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rgbdc_pkg::REG_BLUE_MASK:    cfg_r.blue  <= rgbdc_pkg::chan_info(cfg_data);
        rgbdc_pkg::REG_RED_MASK:     cfg_r.red   <= rgbdc_pkg::chan_info(cfg_data);
        rgbdc_pkg::REG_GREEN_MASK:   cfg_r.green <= rgbdc_pkg::chan_info(cfg_data);
        rgbdc_pkg::REG_OUTPUT_DEPTH: cfg_r.depth <= cfg_data[0];
        rgbdc_pkg::REG_COMPOSE_MODE: cfg_r.mode  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Pipeline enables
  assign s2_en     = !out_valid_r || out_tready;
  assign s1_en     = !s1_valid_r || s2_en;
  assign in_tready = s1_en;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_en) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && s1_en) begin
      s1_item_r.main_blue  <= in_tdata[7:0];
      s1_item_r.main_green <= in_tdata[15:8];
      s1_item_r.main_red   <= in_tdata[23:16];
      s1_item_r.menu_blue  <= in_tdata[31:24];
      s1_item_r.menu_green <= in_tdata[39:32];
      s1_item_r.menu_red   <= in_tdata[47:40];
      s1_item_r.alpha_flag <= in_tdata[55:48];
    end
  end

  rgbdc_convert u_convert (
    .cfg  (cfg_r),
    .item (s1_item_r),
    .res  (res_nxt)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_en) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en && s1_valid_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {res_r.alpha_out, res_r.display_word};
  assign out_tuser  = res_r.write_enable;

  // Checks
  `RGBDC_ASSERT_RST(a_no_write_zero, clk, rst_n,
    out_valid_r && !res_r.write_enable |-> res_r.display_word == 32'h0,
    "display word nonzero without write enable")
  `RGBDC_ASSERT_RST(a_item_advances, clk, rst_n,
    s1_valid_r && s2_en |=> out_valid_r,
    "item in input register lost on advance")
  `RGBDC_ASSERT_RST(a_ready_low_full, clk, rst_n,
    !in_tready |-> s1_valid_r && out_valid_r && !out_tready,
    "input stalled with room in the pipe")
  `RGBDC_ASSERT_ALWAYS(a_reset_empty, clk,
    $past(!rst_n) |-> !s1_valid_r && !out_valid_r,
    "pipe not empty after reset")

endmodule

>>> rtl/core/rgbdc_convert.sv
// Compose select and 16/32-bit pixel packing for one registered item.
// Depends on rgbdc_pkg; purely combinational, sits between two registers.
module rgbdc_convert (
  input  rgbdc_pkg::cfg_t     cfg,
  input  rgbdc_pkg::in_item_t item,
  output rgbdc_pkg::res_t     res
);

  // Top n bits of a channel byte
  function automatic logic [7:0] keep_top(input logic [7:0] c, input logic [3:0] n);
    logic [7:0] k;
    k = 8'hFF << (4'd8 - n);
    return c & k;
  endfunction

  function automatic logic [31:0] pack(input rgbdc_pkg::cfg_t c,
                                       input logic [7:0] b, input logic [7:0] g,
                                       input logic [7:0] r, input logic menu_order);
    logic [15:0] w16;
    logic [15:0] bw;
    logic [15:0] gw;
    logic [15:0] rw;
    logic [31:0] w;
    bw  = {8'h00, keep_top(b, c.blue.n)} >> (4'd8 - c.blue.n);
    gw  = {8'h00, keep_top(g, c.green.n)} << c.green.sh;
    rw  = {8'h00, keep_top(r, c.red.n)} << c.red.sh;
    w16 = bw | gw | rw;
    if (c.depth == rgbdc_pkg::DEPTH_16) begin
      w = {16'h0000, w16};
    end else if (menu_order) begin
      w = {b, g, r, 8'h00};
    end else begin
      w = {8'h00, r, g, b};
    end
    return w;
  endfunction

  logic alpha_zero;
  logic menu_vis;

  assign alpha_zero = (item.alpha_flag == 8'h00);
  assign menu_vis   = item.alpha_flag[rgbdc_pkg::ALPHA_MENU_BIT];

  // Compose select
  always_comb begin
    res.display_word = 32'h0;
    res.write_enable = 1'b0;
    res.alpha_out    = item.alpha_flag;
    case (cfg.mode)
      rgbdc_pkg::MODE_MENU_DRAW: begin
        if (menu_vis) begin
          res.display_word = pack(cfg, item.menu_blue, item.menu_green, item.menu_red, 1'b1);
          res.write_enable = 1'b1;
        end else if (!alpha_zero) begin
          res.display_word = pack(cfg, item.main_blue, item.main_green, item.main_red, 1'b1);
          res.write_enable = 1'b1;
          res.alpha_out    = 8'h00;
        end else begin
          res.alpha_out    = 8'h00;
        end
      end
      rgbdc_pkg::MODE_MAIN_UNDER: begin
        if (alpha_zero) begin
          res.display_word = pack(cfg, item.main_blue, item.main_green, item.main_red, 1'b0);
          res.write_enable = 1'b1;
        end
      end
      default: begin
        res.display_word = pack(cfg, item.main_blue, item.main_green, item.main_red, 1'b0);
        res.write_enable = 1'b1;
      end
    endcase
  end

endmodule
